@@ hw/rtl/sbsn_pkg.sv @@
// Package for the spectrum bin sqrt/section normalize unit.
// Payload structs, controller states, command/status structs and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbsn_pkg;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_NORM  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] REG_MIN_MZ    = 2'd0;
	localparam logic [1:0] REG_MAX_MZ    = 2'd1;
	localparam logic [1:0] REG_BIN_WIDTH = 2'd2;
	localparam logic [1:0] REG_SECTIONS  = 2'd3;

	localparam logic [15:0] FULL_SCALE = 16'd51200;
	localparam logic [19:0] RESET_MAX_MZ = 20'd512000;
	localparam logic [19:0] RESET_BIN_WIDTH = 20'd256;
	localparam logic [4:0] RESET_SECTIONS = 5'd10;

	typedef struct packed {
		logic [1:0]  action;
		logic [19:0] peak_mz;
		logic [31:0] peak_intensity;
		logic [10:0] bin_number;
	} sbsn_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [19:0] bin_mz;
		logic [15:0] bin_value;
	} sbsn_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NB_DIV,
		ST_DISPATCH,
		ST_SZ_DIV,
		ST_ADD_DIV,
		ST_ADD_SQRT,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_CLEAR,
		ST_NORM_INIT,
		ST_NORM_SCAN,
		ST_RD_SEC,
		ST_RD_FETCH,
		ST_RD_DIV,
		ST_RESULT
	} sbsn_state_t;

	typedef enum logic [1:0] {
		DV_NB,
		DV_SZ,
		DV_IDX,
		DV_SEC
	} sbsn_div_sel_t;

	typedef enum logic [1:0] {
		RS_NORM,
		RS_READ_OOR,
		RS_READ_ZERO,
		RS_READ_VAL
	} sbsn_res_sel_t;

	typedef struct packed {
		logic          load_item;
		logic          div_start;
		sbsn_div_sel_t div_sel;
		logic          latch_nb;
		logic          latch_sz;
		logic          sqrt_start;
		logic          add_read;
		logic          add_write;
		logic          clr_start;
		logic          clr_step;
		logic          norm_start;
		logic          norm_step;
		logic          rd_fetch;
		logic          rd_div_start;
		logic          res_load;
		sbsn_res_sel_t res_sel;
		logic          set_flag;
		logic          clear_flag;
	} sbsn_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       div_busy;
		logic       sqrt_busy;
		logic       drop_add;
		logic       clr_done;
		logic       norm_done;
		logic       rd_oor;
		logic       norm_flag;
		logic       sz_zero;
		logic       out_full;
	} sbsn_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/spectrum_bin_sqrt_section_normalize_unit.sv @@
// Top level of the spectrum bin sqrt/section normalize unit.
// Depends on sbsn_pkg, sbsn_ctrl, sbsn_dp.
//
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | sbsn_in_t (action, peak_mz, peak_intensity, bin_number)
//  out     | out_valid/out_stall | sbsn_out_t (result_kind, bin_mz, bin_value)
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The bit-serial divider is shared. Add: bin count and index divisions, square root
// overlapped. Normalize: bin count and section size divisions, a scan of every bin.
// Read: bin count, section size, section and value divisions; no section division if
// no section holds a full bin, only the first two out of range. Clear: bin count
// division, then one bin zeroed per cycle, as after reset, with in_stall high.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_bin_sqrt_section_normalize_unit import sbsn_pkg::*; #(
	parameter int MAX_BINS = 2048,
	parameter int MAX_SECTIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire sbsn_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output sbsn_out_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	sbsn_cmd_t  cmd;
	sbsn_stat_t stat;

	assign cfg_ready = 1'b1;

	sbsn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.stat(stat), .cmd(cmd)
	);

	sbsn_dp #(.MAX_BINS(MAX_BINS), .MAX_SECTIONS(MAX_SECTIONS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_data(in_data), .cmd(cmd), .stat(stat),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
`default_nettype wire

@@ hw/rtl/sbsn_ctrl.sv @@
// Controller state machine for the spectrum bin normalize unit.
// Depends on sbsn_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps
`default_nettype none
module sbsn_ctrl import sbsn_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire sbsn_stat_t stat,
	output sbsn_cmd_t       cmd
);

	sbsn_state_t state_q, state_d;

	// reset starts with a sweep that zeroes the bin store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = DV_NB;
					state_d = ST_NB_DIV;
				end
			end
			ST_NB_DIV: begin
				if (!stat.div_busy) begin
					cmd.latch_nb = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.action)
					ACT_ADD: begin
						if (stat.drop_add) begin
							state_d = ST_IDLE;
						end else begin
							cmd.div_start = 1'b1;
							cmd.div_sel = DV_IDX;
							cmd.sqrt_start = 1'b1;
							state_d = ST_ADD_DIV;
						end
					end
					ACT_CLEAR: begin
						cmd.clr_start = 1'b1;
						cmd.clear_flag = 1'b1;
						state_d = ST_CLEAR;
					end
					default: begin
						cmd.div_start = 1'b1;
						cmd.div_sel = DV_SZ;
						state_d = ST_SZ_DIV;
					end
				endcase
			end
			ST_SZ_DIV: begin
				if (!stat.div_busy) begin
					cmd.latch_sz = 1'b1;
					if (stat.action == ACT_NORM) begin
						state_d = ST_NORM_INIT;
					end else begin
						state_d = ST_RD_SEC;
					end
				end
			end
			ST_ADD_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_ADD_SQRT;
				end
			end
			ST_ADD_SQRT: begin
				if (stat.drop_add) begin
					state_d = ST_IDLE;
				end else if (!stat.sqrt_busy) begin
					cmd.add_read = 1'b1;
					state_d = ST_ADD_RD;
				end
			end
			ST_ADD_RD: begin
				cmd.add_read = 1'b1;
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.add_write = 1'b1;
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_NORM_INIT: begin
				cmd.norm_start = 1'b1;
				state_d = ST_NORM_SCAN;
			end
			ST_NORM_SCAN: begin
				cmd.norm_step = 1'b1;
				if (stat.norm_done) begin
					cmd.set_flag = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RD_SEC: begin
				if (stat.rd_oor) begin
					state_d = ST_RESULT;
				end else if (stat.sz_zero) begin
					cmd.rd_fetch = 1'b1;
					state_d = ST_RD_FETCH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DV_SEC;
					state_d = ST_RD_FETCH;
				end
			end
			ST_RD_FETCH: begin
				if (!stat.div_busy) begin
					cmd.rd_fetch = 1'b1;
					state_d = ST_RD_DIV;
				end
			end
			ST_RD_DIV: begin
				cmd.rd_div_start = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!stat.out_full && !stat.div_busy) begin
					cmd.res_load = 1'b1;
					if (stat.action == ACT_NORM) begin
						cmd.res_sel = RS_NORM;
					end else if (stat.rd_oor) begin
						cmd.res_sel = RS_READ_OOR;
					end else if (!stat.norm_flag) begin
						cmd.res_sel = RS_READ_ZERO;
					end else begin
						cmd.res_sel = RS_READ_VAL;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_write, cmd.clr_step, cmd.norm_step, cmd.res_load}))
		else $error("conflicting datapath commands");
	a_res_ret: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> (state_q == ST_IDLE))
		else $error("result load not followed by idle");

endmodule
`default_nettype wire

@@ hw/rtl/sbsn_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// 64-bit dividend, 32-bit divisor. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sbsn_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [63:0]      quotient
);

	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign trial = shifted - {1'b0, dsr_q};
	assign busy = (cnt_q != 7'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sbsn_sqrt.sv @@
// Iterative integer square root of intensity * 65536, one result bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sbsn_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] intensity,
	output logic             busy,
	output logic [31:0]      root
);

	logic [5:0]  cnt_q;
	logic [63:0] val_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [33:0] cur;
	logic [33:0] trial;

	assign cur = {rem_q[31:0], val_q[63:62]};
	assign trial = cur - {root_q, 2'b01};
	assign busy = (cnt_q != 6'd0);
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= {intensity, 32'd0} >> 16;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy) begin
			val_q <= {val_q[61:0], 2'b00};
			if (!trial[33]) begin
				rem_q <= trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= cur;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sbsn_dp.sv @@
// Datapath: config registers, bin memory, section maxima, divider, square root
// and output register. Depends on sbsn_pkg, sbsn_div, sbsn_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module sbsn_dp import sbsn_pkg::*; #(
	parameter int MAX_BINS = 2048,
	parameter int MAX_SECTIONS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [1:0] cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire sbsn_in_t   in_data,
	input  wire sbsn_cmd_t  cmd,
	output sbsn_stat_t      stat,
	output logic            out_valid,
	input  wire logic       out_stall,
	output sbsn_out_t       out_data
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = $clog2(MAX_BINS + 1);
	localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	logic [19:0] min_mz_q, max_mz_q, bin_width_q;
	logic [4:0]  sections_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mz_q    <= '0;
			max_mz_q    <= RESET_MAX_MZ;
			bin_width_q <= RESET_BIN_WIDTH;
			sections_q  <= RESET_SECTIONS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_MZ:    min_mz_q <= cfg_data;
				REG_MAX_MZ:    max_mz_q <= cfg_data;
				REG_BIN_WIDTH: bin_width_q <= cfg_data;
				REG_SECTIONS:  sections_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	logic [19:0] eff_w;
	logic [6:0]  eff_s;
	assign eff_w = (bin_width_q == '0) ? 20'd1 : bin_width_q;
	always_comb begin
		if (sections_q == '0) begin
			eff_s = 7'd1;
		end else if ({2'b00, sections_q} > 7'(MAX_SECTIONS)) begin
			eff_s = 7'(MAX_SECTIONS);
		end else begin
			eff_s = {2'b00, sections_q};
		end
	end

	sbsn_in_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	logic        div_busy;
	logic [63:0] div_q;
	logic [63:0] div_a;
	logic [31:0] div_b;
	logic [31:0] max_rd_q;
	logic [31:0] mem_rd_s1;
	logic [CW-1:0] nb_q;
	logic [CW-1:0] sz_q;

	always_comb begin
		case (cmd.div_sel)
			DV_NB: begin
				div_a = (max_mz_q > min_mz_q) ? 64'(max_mz_q - min_mz_q) : 64'd0;
				div_b = 32'(eff_w);
			end
			DV_SZ: begin
				div_a = 64'(nb_q);
				div_b = 32'(eff_s);
			end
			DV_IDX: begin
				div_a = 64'(item_q.peak_mz - min_mz_q);
				div_b = 32'(eff_w);
			end
			default: begin
				div_a = 64'(item_q.bin_number);
				div_b = 32'(sz_q);
			end
		endcase
		if (cmd.rd_div_start) begin
			div_a = 64'(mem_rd_s1) * 64'(FULL_SCALE);
			div_b = (max_rd_q == '0) ? 32'd1 : max_rd_q;
		end
	end

	sbsn_div u_div (
		.clk(clk), .arst_n(arst_n),
		.start(cmd.div_start | cmd.rd_div_start),
		.dividend(div_a), .divisor(div_b),
		.busy(div_busy), .quotient(div_q)
	);

	logic        sqrt_busy;
	logic [31:0] root;
	sbsn_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start),
		.intensity(item_q.peak_intensity), .busy(sqrt_busy), .root(root)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_nb) begin
			nb_q <= (div_q > 64'(MAX_BINS)) ? CW'(MAX_BINS) : div_q[CW-1:0];
		end
		if (cmd.latch_sz) begin
			sz_q <= div_q[CW-1:0];
		end
	end

	// drop test: below min or no bins on dispatch, index past bins after the division
	logic drop_q;
	logic add_div_seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
			add_div_seen_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				add_div_seen_q <= 1'b0;
				drop_q <= 1'b0;
			end else if (cmd.div_start && cmd.div_sel == DV_IDX) begin
				add_div_seen_q <= 1'b1;
			end else if (add_div_seen_q && !div_busy) begin
				add_div_seen_q <= 1'b0;
				drop_q <= (div_q >= 64'(nb_q));
			end
		end
	end

	logic below_min;
	assign below_min = (item_q.peak_mz < min_mz_q) || (nb_q == '0);

	// bin memory
	logic [31:0] mem [MAX_BINS];
	logic [AW-1:0] idx_q;
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] rd_addr;
	logic          scan_busy_q;
	logic          scan_v_s1;
	logic [CW-1:0] scan_cnt_q;
	logic          norm_flag_q;

	always_comb begin
		if (cmd.add_read) begin
			rd_addr = div_q[AW-1:0];
		end else if (cmd.rd_fetch) begin
			rd_addr = AW'(item_q.bin_number);
		end else begin
			rd_addr = sweep_q;
		end
	end

	always_ff @(posedge clk) begin
		mem_rd_s1 <= mem[rd_addr];
		if (cmd.add_read) begin
			idx_q <= div_q[AW-1:0];
		end
		if (cmd.add_write) begin
			mem[idx_q] <= ({1'b0, mem_rd_s1} + {1'b0, root} > 33'hFFFFFFFF)
				? 32'hFFFFFFFF : mem_rd_s1 + root;
		end else if (cmd.clr_step) begin
			mem[sweep_q] <= '0;
		end
	end

	logic clr_done;
	assign clr_done = (sweep_q == AW'(MAX_BINS - 1));

	// section maxima, sections tracked incrementally during the scan
	logic [31:0]   smax_q [MAX_SECTIONS];
	logic [SW-1:0] sec_q;
	logic [CW-1:0] in_sec_q;
	logic [SW-1:0] sec_s1;
	logic [SW-1:0] last_sec;
	logic          norm_done;
	assign last_sec = SW'(eff_s - 7'd1);
	assign norm_done = !scan_busy_q && !scan_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			scan_busy_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			norm_flag_q <= 1'b0;
		end else begin
			if (cmd.clr_start || cmd.norm_start) begin
				sweep_q <= '0;
			end else if (cmd.clr_step) begin
				sweep_q <= sweep_q + AW'(1);
			end else if (scan_busy_q) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.norm_start) begin
				scan_busy_q <= (nb_q != '0);
			end else if (scan_busy_q && scan_cnt_q == nb_q - CW'(1)) begin
				scan_busy_q <= 1'b0;
			end
			scan_v_s1 <= scan_busy_q;
			if (cmd.set_flag) begin
				norm_flag_q <= 1'b1;
			end else if (cmd.clear_flag) begin
				norm_flag_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sec_s1 <= sec_q;
		if (cmd.norm_start) begin
			scan_cnt_q <= '0;
			sec_q <= (sz_q == '0) ? last_sec : '0;
			in_sec_q <= '0;
			for (int k = 0; k < MAX_SECTIONS; k++) begin
				if (k < int'(eff_s)) begin
					smax_q[k] <= '0;
				end
			end
		end else begin
			if (scan_busy_q) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
				if (sz_q != '0 && sec_q != last_sec) begin
					if (in_sec_q == sz_q - CW'(1)) begin
						in_sec_q <= '0;
						sec_q <= sec_q + SW'(1);
					end else begin
						in_sec_q <= in_sec_q + CW'(1);
					end
				end
			end
			if (scan_v_s1 && mem_rd_s1 > smax_q[sec_s1]) begin
				smax_q[sec_s1] <= mem_rd_s1;
			end
		end
	end

	// read path
	logic [SW-1:0] rd_sec;
	always_comb begin
		if (sz_q == '0 || div_q >= 64'(eff_s)) begin
			rd_sec = last_sec;
		end else begin
			rd_sec = div_q[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_fetch) begin
			max_rd_q <= smax_q[rd_sec];
		end
	end

	logic [19:0] mz_calc;
	assign mz_calc = 20'(32'(item_q.bin_number) * 32'(eff_w) + 32'(min_mz_q));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				RS_NORM: out_data <= '{result_kind: 1'b0, bin_mz: '0, bin_value: '0};
				RS_READ_OOR: out_data <= '{result_kind: 1'b1, bin_mz: '0, bin_value: '0};
				RS_READ_ZERO: out_data <= '{result_kind: 1'b1, bin_mz: mz_calc,
					bin_value: '0};
				default: out_data <= '{result_kind: 1'b1, bin_mz: mz_calc,
					bin_value: (div_q > 64'(FULL_SCALE)) ? FULL_SCALE : div_q[15:0]};
			endcase
		end
	end

	always_comb begin
		stat = '0;
		stat.action = item_q.action;
		stat.div_busy = div_busy;
		stat.sqrt_busy = sqrt_busy;
		stat.drop_add = below_min || drop_q;
		stat.clr_done = clr_done;
		stat.norm_done = norm_done;
		stat.rd_oor = (CW'(item_q.bin_number) >= nb_q) || (32'(item_q.bin_number) >=
			32'(MAX_BINS));
		stat.norm_flag = norm_flag_q;
		stat.sz_zero = (sz_q == '0);
		stat.out_full = out_valid && out_stall;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_valid && out_stall))
		else $error("result overwritten");
	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.bin_value <= FULL_SCALE)
		else $error("bin value out of range");
	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_write |-> !scan_busy_q)
		else $error("write during scan");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for spectrum_bin_sqrt_section_normalize_unit: peak binning, normalize, read, clear.
// A queue-fed driver and a clocked monitor check results against an in-bench bin store predictor.
// Depends on sbsn_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;
	import sbsn_pkg::*;

	localparam int NBINS = 2048;
	localparam int NSECS = 16;
	localparam int SETTLE = 2600;
	localparam longint LIMIT = 40000000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sbsn_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sbsn_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_MIN_MZ;
	logic [19:0] cfg_data = '0;

	spectrum_bin_sqrt_section_normalize_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// predictor state
	logic [19:0] p_min, p_max, p_width;
	logic [4:0] p_secs;
	logic [31:0] bin_sum [NBINS];
	logic [31:0] sec_peak [NSECS];
	bit sec_known [NSECS];
	bit norm_done;

	sbsn_in_t request_q[$];
	sbsn_out_t result_q[$];
	int errors = 0;
	longint cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req = 0;
	bit hold_used = 0;
	int hold_cnt = 0;
	bit in_took = 0;
	bit cfg_took = 0;

	function automatic int unsigned width_eff();
		return (p_width == 0) ? 1 : p_width;
	endfunction

	function automatic int unsigned secs_eff();
		if (p_secs == 0) return 1;
		if (p_secs > NSECS) return NSECS;
		return p_secs;
	endfunction

	function automatic int unsigned bin_count();
		int unsigned n;
		if (p_max <= p_min) return 0;
		n = (p_max - p_min) / width_eff();
		return (n > NBINS) ? NBINS : n;
	endfunction

	function automatic int unsigned section_for(int unsigned b);
		int unsigned s, sz, sec;
		s = secs_eff();
		sz = bin_count() / s;
		if (sz == 0) return s - 1;
		sec = b / sz;
		return (sec >= s) ? s - 1 : sec;
	endfunction

	function automatic logic [31:0] root_q16_8(logic [31:0] x);
		logic [63:0] v, res, bt;
		v = {16'd0, x, 16'd0};
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res[31:0];
	endfunction

	// predicts one request and queues it, with its expected result when it has one
	task automatic push_request(sbsn_in_t it);
		int unsigned nb, idx, s;
		logic [31:0] r, sum, m;
		logic [63:0] v;
		sbsn_out_t o;
		nb = bin_count();
		s = secs_eff();
		if (it.action == ACT_READ && norm_done && it.bin_number < nb
				&& !sec_known[section_for(it.bin_number)])
			it.action = ACT_NORM;
		case (it.action)
			ACT_ADD: begin
				if (it.peak_mz >= p_min) begin
					idx = (it.peak_mz - p_min) / width_eff();
					if (idx < nb) begin
						r = root_q16_8(it.peak_intensity);
						sum = bin_sum[idx] + r;
						if (sum < r) sum = 32'hFFFF_FFFF;
						bin_sum[idx] = sum;
					end
				end
			end
			ACT_NORM: begin
				for (int k = 0; k < s; k++) begin
					sec_peak[k] = 0;
					sec_known[k] = 1;
				end
				for (int b = 0; b < nb; b++)
					if (bin_sum[b] > sec_peak[section_for(b)])
						sec_peak[section_for(b)] = bin_sum[b];
				norm_done = 1;
				o = '0;
				result_q.insert(result_q.size(), o);
			end
			ACT_READ: begin
				o = '0;
				o.result_kind = 1'b1;
				if (it.bin_number < nb) begin
					o.bin_mz = it.bin_number * width_eff() + p_min;
					if (norm_done) begin
						m = sec_peak[section_for(it.bin_number)];
						if (m == 0) m = 1;
						v = {32'd0, bin_sum[it.bin_number]} * 64'd51200 / m;
						o.bin_value = (v > 51200) ? FULL_SCALE : v[15:0];
					end
				end
				result_q.insert(result_q.size(), o);
			end
			default: begin
				for (int b = 0; b < NBINS; b++) bin_sum[b] = 0;
				norm_done = 0;
			end
		endcase
		request_q.insert(request_q.size(), it);
	endtask

	function automatic sbsn_in_t mk(logic [1:0] a, logic [19:0] mz, logic [31:0] ity,
			logic [10:0] bn);
		sbsn_in_t it;
		it.action = a;
		it.peak_mz = mz;
		it.peak_intensity = ity;
		it.bin_number = bn;
		return it;
	endfunction

	function automatic sbsn_in_t rand_request(int add_w, int norm_w, bit heavy);
		sbsn_in_t it;
		int unsigned nb, r;
		nb = bin_count();
		it.action = ACT_READ;
		it.peak_mz = $urandom;
		it.peak_intensity = $urandom;
		it.bin_number = $urandom;
		r = $urandom_range(0, 99);
		if (r < add_w) it.action = ACT_ADD;
		else if (r < add_w + norm_w) it.action = ACT_NORM;
		else if (r < add_w + norm_w + 2) it.action = ACT_CLEAR;
		if ($urandom_range(0, 9) < 8)
			it.peak_mz = p_min + $urandom_range(0, (nb + 1) * width_eff());
		case ($urandom_range(0, 5))
			0: it.peak_intensity = 0;
			1: it.peak_intensity = 32'hFFFF_FFFF;
			2: it.peak_intensity = $urandom_range(0, 65535);
			default: ;
		endcase
		if (heavy && $urandom_range(0, 9) < 8) it.peak_intensity = 32'hFFFF_FFFF;
		if ($urandom_range(0, 9) < 8) it.bin_number = $urandom_range(0, nb + 1);
		return it;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MIN_MZ: p_min = val;
			REG_MAX_MZ: p_max = val;
			REG_BIN_WIDTH: p_width = val;
			default: p_secs = val[4:0];
		endcase
	endtask

	task automatic drain();
		while (request_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(logic [19:0] mn, logic [19:0] mx, logic [19:0] w, logic [4:0] s,
			int n, int add_w, int norm_w, bit heavy, int si, int ri);
		drain();
		write_reg(REG_MIN_MZ, mn);
		write_reg(REG_MAX_MZ, mx);
		write_reg(REG_BIN_WIDTH, w);
		write_reg(REG_SECTIONS, s);
		send_idle = si;
		recv_idle = ri;
		for (int i = 0; i < n; i++) push_request(rand_request(add_w, norm_w, heavy));
	endtask

	initial begin
		p_min = 0;
		p_max = RESET_MAX_MZ;
		p_width = RESET_BIN_WIDTH;
		p_secs = RESET_SECTIONS;
		norm_done = 0;
		for (int b = 0; b < NBINS; b++) bin_sum[b] = 0;
		for (int k = 0; k < NSECS; k++) begin
			sec_peak[k] = 0;
			sec_known[k] = 0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset configuration (2000 bins, 10 sections)
		push_request(mk(ACT_ADD, 20'd0, 32'hFFFF_FFFF, 11'd0));
		push_request(mk(ACT_ADD, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_ADD, 20'd511999, 32'd1, 11'd0));
		push_request(mk(ACT_ADD, 20'd512000, 32'd12345, 11'd0));
		push_request(mk(ACT_ADD, 20'hFFFFF, 32'hFFFF_FFFF, 11'd0));
		push_request(mk(ACT_ADD, 20'd300, 32'd99999, 11'd0));
		push_request(mk(ACT_READ, 20'hFFFFF, 32'hFFFF_FFFF, 11'd0));
		push_request(mk(ACT_NORM, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd1));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd300));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd1999));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd2000));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd2047));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd1000));
		push_request(mk(ACT_ADD, 20'd10, 32'hFFFF_FFFF, 11'd0));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_CLEAR, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_NORM, 20'd0, 32'd0, 11'd0));
		push_request(mk(ACT_READ, 20'd0, 32'd0, 11'd1999));

		run_phase(20'd0, 20'd512000, 20'd256, 5'd10, 300, 50, 5, 0, 0, 0);
		run_phase(20'd1000, 20'd12100, 20'd300, 5'd5, 300, 50, 6, 0, 76, 0);
		hold_req = 1;
		run_phase(20'd0, 20'hFFFFF, 20'd1, 5'd16, 200, 50, 4, 0, 0, 76);
		run_phase(20'd0, 20'd256, 20'd256, 5'd1, 400, 85, 3, 1, 9, 9);
		run_phase(20'd5000, 20'd5280, 20'd40, 5'd16, 200, 45, 8, 0, 76, 0);
		run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 5'd0, 100, 40, 8, 0, 0, 76);
		run_phase(20'd0, 20'hFFFFF, 20'hFFFFF, 5'd31, 200, 45, 8, 1, 9, 9);
		run_phase(20'd300, 20'd400, 20'd7, 5'd3, 150, 45, 8, 0, 0, 0);
		drain();
		if (errors == 0 && result_q.size() == 0) begin
			$display("PASS spectrum_bin_sqrt_section_normalize_unit");
		end else begin
			$display("FAIL spectrum_bin_sqrt_section_normalize_unit");
		end
		$finish;
	end

	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		cfg_took <= cfg_valid && cfg_ready;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL spectrum_bin_sqrt_section_normalize_unit");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				in_valid <= 1'b1;
				in_data <= request_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req && !hold_used) begin
			out_stall <= 1'b1;
			hold_cnt <= 4000;
			hold_used <= 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		sbsn_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$display("%0t unexpected result %p", $time, out_data);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (e.result_kind !== out_data.result_kind) begin
					$display("%0t result_kind exp %0d got %0d", $time, e.result_kind,
						out_data.result_kind);
					errors++;
				end
				if (e.bin_mz !== out_data.bin_mz) begin
					$display("%0t bin_mz exp %0d got %0d", $time, e.bin_mz, out_data.bin_mz);
					errors++;
				end
				if (e.bin_value !== out_data.bin_value) begin
					$display("%0t bin_value exp %0d got %0d", $time, e.bin_value,
						out_data.bin_value);
					errors++;
				end
			end
		end
	end
endmodule

@@ spectrum_bin_sqrt_section_normalize_unit.f @@
hw/rtl/sbsn_pkg.sv
hw/rtl/sbsn_ctrl.sv
hw/rtl/sbsn_div.sv
hw/rtl/sbsn_sqrt.sv
hw/rtl/sbsn_dp.sv
hw/rtl/spectrum_bin_sqrt_section_normalize_unit.sv
tb/sv/tb_top.sv
